### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; the including module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LCSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define LCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LCSR_ASSERT(lbl, prop, msg)

`define LCSR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/lcsr_pkg.sv
`default_nettype none

package lcsr_pkg;

	localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] LCG_ADD = 64'd1442695040888963407;

	localparam int NEWTON_ROUNDS = 6;
	localparam int REV_STEPS     = 7;

	// register select, paddr[3]
	localparam logic REG_LAYER_SALT = 1'b0;
	localparam logic REG_RETURN_ODD = 1'b1;

	// one transaction in flight through a Newton round
	typedef struct packed {
		logic [63:0]        x;
		logic [63:0]        inv;
		logic [63:0]        c;
		logic signed [31:0] tx;
		logic signed [31:0] tz;
	} item_t;

	// low 64 bits of a 64x64 product from three 32x32 multipliers
	function automatic logic [63:0] mul64lo(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
		ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
		lh = a[31:0] * b[63:32];
		hl = a[63:32] * b[31:0];
		return ll + {lh + hl, 32'd0};
	endfunction

	function automatic logic [63:0] sext32(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/lcsr_if.sv
`default_nettype none

interface lcsr_chunk_if;
	logic               valid;
	logic               ready;
	logic [63:0]        chunk_seed;
	logic signed [31:0] tile_x;
	logic signed [31:0] tile_z;

	modport source(output valid, chunk_seed, tile_x, tile_z, input ready);
	modport sink(input valid, chunk_seed, tile_x, tile_z, output ready);
endinterface

interface lcsr_world_if;
	logic        valid;
	logic        ready;
	logic [63:0] world_seed;

	modport source(output valid, world_seed, input ready);
	modport sink(input valid, world_seed, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcg_chain_seed_reversal_unit.sv
`default_nettype none

`include "assert_macros.svh"

// Channel   Dir  Payload                              Handshake
// chunk     in   chunk_seed[63:0], tile_x, tile_z     valid/ready
// world     out  world_seed[63:0]                     valid/ready
// apb       in   paddr[3:0], pwdata[63:0] / prdata    psel/penable/pwrite, pready=1
//
// One transaction enters per cycle while the skid entry is empty; the path is 7 reverse
// steps x 6 Newton rounds x 3 stages, plus the output register.
// The pipeline is bounded by the three-stage Newton round (at most two 64-bit
// wrap-around products, built from 32x32 multipliers, per stage).
// Reset clears all valid bits, layer_salt and return_odd.
// A stalled output parks at most one result in a skid entry; chunk.ready is
// that entry being empty, so input keeps flowing while only the output register holds a result.
module lcg_chain_seed_reversal_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lcsr_chunk_if.sink       chunk,
	lcsr_world_if.source     world,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	// ------------------------------------------------------------------
	// Configuration registers: layer_salt at 0x0, return_odd at 0x8
	// ------------------------------------------------------------------
	logic [63:0] layer_salt_q;
	logic        return_odd_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_salt_q <= '0;
			return_odd_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				lcsr_pkg::REG_LAYER_SALT: layer_salt_q <= pwdata;
				lcsr_pkg::REG_RETURN_ODD: return_odd_q <= pwdata[0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			lcsr_pkg::REG_LAYER_SALT: prdata = layer_salt_q;
			lcsr_pkg::REG_RETURN_ODD: prdata = {63'd0, return_odd_q};
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Step chain. Config only changes while idle (the user must keep to this; the block
	// does not enforce it), so each step reads the registers directly, not via the transaction.
	// ------------------------------------------------------------------
	logic            en;
	logic            st_v  [0:lcsr_pkg::REV_STEPS];
	lcsr_pkg::item_t st_it [0:lcsr_pkg::REV_STEPS];

	assign chunk.ready = en;

	// stage 0 source: the input channel
	always_comb begin
		st_it[0].x   = chunk.chunk_seed;
		st_it[0].inv = '0;
		st_it[0].c   = '0;
		st_it[0].tx  = chunk.tile_x;
		st_it[0].tz  = chunk.tile_z;
	end
	assign st_v[0] = chunk.valid;

	for (genvar k = 0; k < lcsr_pkg::REV_STEPS; k++) begin : g_step
		logic [63:0] outv;
		logic [63:0] salt;
		logic        parity;

		// parity of a sign-extended tile is its own bit 0
		if (k == 0 || k == 2) begin : g_sel
			assign outv = st_it[k].x;
			assign salt = lcsr_pkg::sext32(st_it[k].tz);
			assign parity = st_it[k].tx[0];
		end else if (k == 1) begin : g_sel
			assign outv = st_it[k].x;
			assign salt = lcsr_pkg::sext32(st_it[k].tx);
			assign parity = st_it[k].tz[0];
		end else if (k == 3) begin : g_sel
			// chunk-to-start: remove tile_x before undoing the start salt
			assign outv = st_it[k].x - lcsr_pkg::sext32(st_it[k].tx);
			assign salt = '0;
			assign parity = layer_salt_q[0];
		end else if (k < lcsr_pkg::REV_STEPS - 1) begin : g_sel
			assign outv = st_it[k].x;
			assign salt = layer_salt_q;
			assign parity = layer_salt_q[0];
		end else begin : g_sel
			assign outv = st_it[k].x;
			assign salt = layer_salt_q;
			assign parity = return_odd_q;
		end

		lcsr_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (st_v[k]),
			.outv     (outv),
			.salt     (salt),
			.parity   (parity),
			.tx       (st_it[k].tx),
			.tz       (st_it[k].tz),
			.out_valid(st_v[k+1]),
			.out_item (st_it[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Output register and skid
	// ------------------------------------------------------------------
	lcsr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (st_v[lcsr_pkg::REV_STEPS]),
		.in_data  (st_it[lcsr_pkg::REV_STEPS].x),
		.out_ready(world.ready),
		.en       (en),
		.out_valid(world.valid),
		.out_data (world.world_seed)
	);

	`LCSR_ASSERT_NEXT(a_salt_write, cfg_wr && paddr[3] == lcsr_pkg::REG_LAYER_SALT,
		layer_salt_q == $past(pwdata), "layer_salt write lost")
	`LCSR_ASSERT_NEXT(a_odd_write, cfg_wr && paddr[3] == lcsr_pkg::REG_RETURN_ODD,
		return_odd_q == $past(pwdata[0]), "return_odd write lost")
	`LCSR_ASSERT_NEXT(a_world_hold, world.valid && !world.ready,
		world.valid && $stable(world.world_seed), "stalled world transaction changed")

endmodule

`default_nettype wire

### hw/rtl/lcsr_round.sv
`default_nettype none

// One Newton/Hensel round in three stages:
//   s1: p = A*x, q = inv^2
//   s2: f = (p+B)*x + c, r = (2p+B)*q
//   s3: inv' = 2inv - r, x' = x - f*inv'
module lcsr_round (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire lcsr_pkg::item_t in_item,
	output logic                 out_valid,
	output lcsr_pkg::item_t      out_item
);

	logic            v_s1, v_s2, v_s3;
	lcsr_pkg::item_t it_s1, it_s2, it_s3;
	logic [63:0]     p_s1, q_s1;
	logic [63:0]     f_s2, r_s2;

	logic [63:0]     p_d, q_d, f_d, r_d, inv_d, x_d;
	lcsr_pkg::item_t nx_d;

	always_comb begin
		p_d   = lcsr_pkg::mul64lo(lcsr_pkg::LCG_MUL, in_item.x);
		q_d   = lcsr_pkg::mul64lo(in_item.inv, in_item.inv);
		f_d   = lcsr_pkg::mul64lo(p_s1 + lcsr_pkg::LCG_ADD, it_s1.x) + it_s1.c;
		r_d   = lcsr_pkg::mul64lo({p_s1[62:0], 1'b0} + lcsr_pkg::LCG_ADD, q_s1);
		inv_d = {it_s2.inv[62:0], 1'b0} - r_s2;
		x_d   = it_s2.x - lcsr_pkg::mul64lo(f_s2, inv_d);
		nx_d     = it_s2;
		nx_d.x   = x_d;
		nx_d.inv = inv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= in_item;
			p_s1  <= p_d;
			q_s1  <= q_d;
			it_s2 <= it_s1;
			f_s2  <= f_d;
			r_s2  <= r_d;
			it_s3 <= nx_d;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = it_s3;

endmodule

`default_nettype wire

### hw/rtl/lcsr_step.sv
`default_nettype none

// One reverse LCG step: root of A*x^2 + B*x + (salt - outv) with the given parity.
module lcsr_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [63:0]        outv,
	input  wire logic [63:0]        salt,
	input  wire logic               parity,
	input  wire logic signed [31:0] tx,
	input  wire logic signed [31:0] tz,
	output logic                    out_valid,
	output lcsr_pkg::item_t         out_item
);

	logic            v_ch  [0:lcsr_pkg::NEWTON_ROUNDS];
	lcsr_pkg::item_t it_ch [0:lcsr_pkg::NEWTON_ROUNDS];

	always_comb begin
		it_ch[0].x   = {63'd0, parity};
		it_ch[0].inv = 64'd1;
		it_ch[0].c   = salt - outv;
		it_ch[0].tx  = tx;
		it_ch[0].tz  = tz;
	end
	assign v_ch[0] = in_valid;

	for (genvar r = 0; r < lcsr_pkg::NEWTON_ROUNDS; r++) begin : g_round
		lcsr_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_ch[r]),
			.in_item  (it_ch[r]),
			.out_valid(v_ch[r+1]),
			.out_item (it_ch[r+1])
		);
	end

	assign out_valid = v_ch[lcsr_pkg::NEWTON_ROUNDS];
	assign out_item  = it_ch[lcsr_pkg::NEWTON_ROUNDS];

endmodule

`default_nettype wire

### hw/rtl/lcsr_out_buf.sv
`default_nettype none

`include "assert_macros.svh"

// Output register plus one skid entry; the pipeline runs while the skid is empty.
module lcsr_out_buf (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [63:0] in_data,
	input  wire logic        out_ready,
	output logic             en,
	output logic             out_valid,
	output logic [63:0]      out_data
);

	logic        out_v_q, skid_v_q;
	logic [63:0] out_d_q, skid_d_q;
	logic        out_free;

	assign en       = !skid_v_q;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (out_free) begin
				out_v_q <= in_valid;
			end else if (in_valid) begin
				skid_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (out_free) begin
				out_d_q <= in_data;
			end else begin
				skid_d_q <= in_data;
			end
		end else if (out_ready) begin
			out_d_q <= skid_d_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	`LCSR_ASSERT(a_skid_needs_out, !skid_v_q || out_v_q, "skid holds data with empty output")
	`LCSR_ASSERT_NEXT(a_skid_catch, out_v_q && !out_ready && !skid_v_q && in_valid, skid_v_q && out_v_q, "stalled transaction not caught in skid")
	`LCSR_ASSERT_NEXT(a_skid_drain, skid_v_q && out_ready, !skid_v_q && out_v_q && out_d_q == $past(skid_d_q), "skid not drained into output")

endmodule

`default_nettype wire

### bench/lcsr_chain_checker.sv
`timescale 1ns / 1ps

module lcsr_chain_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lcsr_chunk_if            chunk,
	lcsr_world_if            world,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output int               pending,
	output int               fail_count,
	output int               checked
);

	logic [63:0] salt_shadow;
	logic        odd_shadow;
	logic [63:0] seeds_due[$];
	logic [63:0] want;

	// root of A*x^2 + B*x + c with the given low bit, inverse of f' refined alongside
	function automatic logic [63:0] hensel_root(input logic [63:0] c, input logic par);
		logic [63:0] x;
		logic [63:0] inv;
		logic [63:0] f;
		logic [63:0] d;
		x = {63'd0, par};
		inv = 64'd1;
		for (int k = 0; k < lcsr_pkg::NEWTON_ROUNDS; k++) begin
			f = lcsr_pkg::LCG_MUL * x * x + lcsr_pkg::LCG_ADD * x + c;
			d = 64'd2 * lcsr_pkg::LCG_MUL * x + lcsr_pkg::LCG_ADD;
			inv = inv + inv - d * inv * inv;
			x = x + (64'd0 - f) * inv;
		end
		return x;
	endfunction

	function automatic logic [63:0] undo_lcg(input logic [63:0] outv, input logic [63:0] salt,
			input logic par);
		return hensel_root(salt - outv, par);
	endfunction

	function automatic logic [63:0] chain_reverse(input logic [63:0] seed,
			input logic signed [31:0] tx32, input logic signed [31:0] tz32,
			input logic [63:0] salt, input logic odd);
		logic [63:0] tx;
		logic [63:0] tz;
		logic [63:0] s;
		tx = {{32{tx32[31]}}, tx32};
		tz = {{32{tz32[31]}}, tz32};
		s = undo_lcg(seed, tz, tx[0]);
		s = undo_lcg(s, tx, tz[0]);
		s = undo_lcg(s, tz, tx[0]) - tx;   // chunk-to-start stage
		s = undo_lcg(s, 64'd0, salt[0]);
		s = undo_lcg(s, salt, salt[0]);
		s = undo_lcg(s, salt, salt[0]);
		return undo_lcg(s, salt, odd);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_shadow <= 64'd0;
			odd_shadow <= 1'b0;
			seeds_due.delete();
			pending <= 0;
			fail_count = 0;
			checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3])
					lcsr_pkg::REG_LAYER_SALT: salt_shadow <= pwdata;
					lcsr_pkg::REG_RETURN_ODD: odd_shadow <= pwdata[0];
					default: ;
				endcase
			end
			// compare before queuing so a stray result never meets its own input
			if (world.valid && world.ready) begin
				if (seeds_due.size() == 0) begin
					$display("%0t world_seed unexpected: expected none, got %h",
						$time, world.world_seed);
					fail_count++;
				end else begin
					want = seeds_due.pop_front();
					checked++;
					if (want !== world.world_seed) begin
						$display("%0t world_seed mismatch: expected %h, got %h",
							$time, want, world.world_seed);
						fail_count++;
					end
				end
			end
			if (chunk.valid && chunk.ready)
				seeds_due.push_back(chain_reverse(chunk.chunk_seed, chunk.tile_x,
					chunk.tile_z, salt_shadow, odd_shadow));
			pending <= seeds_due.size();
		end
	end

endmodule

### bench/lcg_chain_seed_reversal_unit_tb.sv
`timescale 1ns / 1ps

module lcg_chain_seed_reversal_unit_tb;

	// byte addresses: 64-bit registers sit on 8-byte slots, paddr[3] picks one
	localparam logic [3:0] ADDR_LAYER_SALT = {lcsr_pkg::REG_LAYER_SALT, 3'b000};
	localparam logic [3:0] ADDR_RETURN_ODD = {lcsr_pkg::REG_RETURN_ODD, 3'b000};

	// longest quiet stretch a correct run can show: the full pipe plus stalls,
	// plus the settling wait at the end, with wide margin
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 160;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int pending;
	int fail_count;
	int checked;
	int sent = 0;
	int settings = 1;      // reset values count as the first setting
	int quiet_cycles = 0;
	int stall_left = 0;
	logic calm = 1'b0;     // set for the tail of the run: no gaps, no stalls

	lcsr_chunk_if chunk_ch();
	lcsr_world_if world_ch();

	lcg_chain_seed_reversal_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chunk   (chunk_ch),
		.world   (world_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lcsr_chain_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.chunk      (chunk_ch),
		.world      (world_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pending    (pending),
		.fail_count (fail_count),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side back-pressure: random bursts of low ready, none once calm.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			world_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			world_ch.ready <= 1'b0;
		end else begin
			world_ch.ready <= 1'b1;
		end
	end

	// Watchdog: any transaction on either channel resets the count.
	always @(posedge clk) begin
		if ((chunk_ch.valid && chunk_ch.ready) || (world_ch.valid && world_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("lcg_chain_seed_reversal_unit_tb: errors");
			$finish;
		end
	end

	// Tile coordinates: extremes, values near zero (both signs), full random.
	function automatic logic signed [31:0] pick_tile();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3: return $urandom_range(0, 127) - 64;
			default: return $urandom;
		endcase
	endfunction

	// One chunk transaction; an optional idle gap goes first unless calm.
	// valid is left high on return so back-to-back items need no toggle.
	task automatic send_chunk(input logic [63:0] seed, input logic signed [31:0] tx,
			input logic signed [31:0] tz);
		if (!calm && $urandom_range(0, 3) == 0) begin
			chunk_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		chunk_ch.valid <= 1'b1;
		chunk_ch.chunk_seed <= seed;
		chunk_ch.tile_x <= tx;
		chunk_ch.tile_z <= tz;
		@(posedge clk);
		while (!chunk_ch.ready) @(posedge clk);
		sent++;
	endtask

	// Stop feeding and wait for every queued result to come back.
	task automatic drain();
		chunk_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// APB write: setup then access; psel stays up between back-to-back writes.
	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// Only called with the pipe empty. odd_word is written whole: the upper
	// bits must be dropped by the block.
	task automatic apply_setting(input logic [63:0] salt, input logic [63:0] odd_word);
		write_reg(ADDR_LAYER_SALT, salt);
		write_reg(ADDR_RETURN_ODD, odd_word);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	// Corners: seed extremes against tile sign/parity combos. With tz = 0 and an
	// odd seed the first step has an odd constant term, so no true root exists;
	// the chain must still carry whatever the iteration lands on.
	task automatic run_directed();
		logic [63:0]        seeds [4];
		logic signed [31:0] xs [5];
		logic signed [31:0] zs [5];
		seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'h8000_0000_0000_0000};
		xs = '{32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, -32'sd1};
		zs = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1};
		foreach (seeds[i])
			foreach (xs[j])
				send_chunk(seeds[i], xs[j], zs[j]);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_chunk({$urandom, $urandom}, pick_tile(), pick_tile());
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		chunk_ch.valid <= 1'b0;
		chunk_ch.chunk_seed <= '0;
		chunk_ch.tile_x <= '0;
		chunk_ch.tile_z <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values first: layer_salt 0, even root
		run_directed();
		drain();

		// all-ones salt; odd select written with a wide value whose bit 0 is clear
		apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
		run_random(150);
		drain();

		apply_setting(64'd0, 64'd1);
		run_random(150);
		drain();

		apply_setting({$urandom, $urandom}, {$urandom, $urandom});
		run_random(200);
		drain();

		apply_setting(64'h8000_0000_0000_0000, 64'd1);
		run_random(150);
		drain();

		// last setting: a stretch with idling, then a clean full-rate tail
		apply_setting({$urandom, $urandom}, 64'd0);
		run_random(200);
		calm = 1'b1;
		run_random(150);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d chunk transactions sent under %0d register settings,", sent, settings);
		$display("%0d world seeds compared against the predicted chain", checked);
		if (fail_count == 0 && pending == 0) begin
			$display("lcg_chain_seed_reversal_unit_tb: clean");
		end else begin
			$display("lcg_chain_seed_reversal_unit_tb: errors");
		end
		$finish;
	end

endmodule
